### design/assert_macros.svh
// Assertion macros used by the table unit's top-level RTL file.
// Depends on nothing; take it in with a plain include of the file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define HKCT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition is never true at a rising clock edge outside reset.
`define HKCT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### design/hkct_pkg.sv
// Shared types, codes and constants of the hashed key counter table.
// Depends on nothing; the interfaces, controller, datapath and top level refer to it by scope.
package hkct_pkg;

  localparam int unsigned SLOT_BITS_DEF   = 13;
  localparam int unsigned PROBE_LIMIT_DEF = 32;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned INDEX_W  = 13;
  localparam int unsigned STATUS_W = 3;

  localparam logic [WORD_W-1:0] HASH_MULT = 32'd2654435761;

  localparam logic [OPCODE_W-1:0] OP_COUNT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_INSERT   = 3'd1,
    ST_FULL     = 3'd2,
    ST_READ     = 3'd3,
    ST_CLEARED  = 3'd4,
    ST_ZERO_KEY = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    RD_HOME,
    RD_NEXT,
    RD_INDEX
  } rd_sel_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HOME,
    S_PROBE,
    S_READ,
    S_DATA,
    S_CLEAR,
    S_RESP_ZERO
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    clr_step;
    logic    drop_inc;
    logic    res_load;
    status_e res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] req_op;
    logic                req_key_zero;
    logic                hit;
    logic                empty;
    logic                probe_last;
    logic                clr_last;
    logic                out_free;
  } dp_status_t;

endpackage

### design/hkct_if.sv
// Request and response channel interfaces of the hashed key counter table.
// Depends on hkct_pkg for field widths.
interface hkct_req_if;
  logic                          valid;
  logic                          ready;
  logic [hkct_pkg::OPCODE_W-1:0] opcode;
  logic [hkct_pkg::WORD_W-1:0]   key;
  logic [hkct_pkg::INDEX_W-1:0]  slot_index;

  modport source (output valid, opcode, key, slot_index, input ready);
  modport sink   (input valid, opcode, key, slot_index, output ready);
endinterface

interface hkct_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hkct_pkg::STATUS_W-1:0] status;
  logic [hkct_pkg::WORD_W-1:0]   slot_key;
  logic [hkct_pkg::WORD_W-1:0]   slot_count;
  logic [hkct_pkg::WORD_W-1:0]   drops;

  modport source (output valid, status, slot_key, slot_count, drops, input ready);
  modport sink   (input valid, status, slot_key, slot_count, drops, output ready);
endinterface

### design/hkct_ram.sv
// Simple dual-port slot memory: one write port, one read port, registered read.
// Depends on nothing.
module hkct_ram #(
  parameter int unsigned ADDR_W = 13,
  parameter int unsigned DATA_W = 64
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/hkct_datapath.sv
// Datapath of the table unit: request capture, hash, probe address, slot
// memory, drop counter and result register. Depends on hkct_pkg, hkct_ram.
module hkct_datapath #(
  parameter int unsigned SLOT_BITS   = hkct_pkg::SLOT_BITS_DEF,
  parameter int unsigned PROBE_LIMIT = hkct_pkg::PROBE_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hkct_pkg::dp_cmd_t             cmd_i,
  output hkct_pkg::dp_status_t          status_o,
  input  logic [hkct_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [hkct_pkg::WORD_W-1:0]   key_i,
  input  logic [hkct_pkg::INDEX_W-1:0]  slot_index_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [hkct_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [hkct_pkg::WORD_W-1:0]   rsp_key_o,
  output logic [hkct_pkg::WORD_W-1:0]   rsp_count_o,
  output logic [hkct_pkg::WORD_W-1:0]   rsp_drops_o
);

  localparam int unsigned W      = hkct_pkg::WORD_W;
  localparam int unsigned PW     = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int unsigned DATA_W = 2 * W;

  logic [W-1:0]         key_q;
  logic [W-1:0]         prod_q;
  logic [SLOT_BITS-1:0] idx_q;
  logic [SLOT_BITS-1:0] slot_q, slot_d;
  logic [PW-1:0]        probe_q, probe_d;
  logic [SLOT_BITS-1:0] clr_q;
  logic [W-1:0]         drop_q, drop_d;
  logic [W-1:0]         drop_inc;

  logic [SLOT_BITS-1:0] home;
  logic [SLOT_BITS-1:0] raddr;
  logic [SLOT_BITS-1:0] waddr;
  logic [DATA_W-1:0]    wdata;
  logic [DATA_W-1:0]    rdata;
  logic [W-1:0]         rd_key;
  logic [W-1:0]         rd_count;
  logic [W-1:0]         count_inc;
  logic                 hit;

  logic                 res_valid_q, res_valid_d;
  logic                 out_free;
  hkct_pkg::status_e    res_status_q;
  logic [W-1:0]         res_key_q, res_count_q, res_drops_q;
  logic [W-1:0]         res_key_d, res_count_d, res_drops_d;

  // Home slot is the top SLOT_BITS bits of the hashed key.
  assign home      = prod_q[W-1 -: SLOT_BITS];
  assign rd_key    = rdata[DATA_W-1 -: W];
  assign rd_count  = rdata[W-1:0];
  assign count_inc = rd_count + 32'd1;
  assign drop_inc  = drop_q + 32'd1;
  assign hit       = (rd_key == key_q);
  assign out_free  = !res_valid_q || rsp_ready_i;

  always_comb begin
    raddr   = home;
    slot_d  = slot_q;
    probe_d = probe_q;
    case (cmd_i.rd_sel)
      hkct_pkg::RD_HOME: begin
        raddr   = home;
        slot_d  = home;
        probe_d = '0;
      end
      hkct_pkg::RD_NEXT: begin
        raddr   = slot_q + 1'b1;
        slot_d  = slot_q + 1'b1;
        probe_d = probe_q + 1'b1;
      end
      hkct_pkg::RD_INDEX: begin
        raddr   = idx_q;
      end
      default: begin
        raddr   = home;
      end
    endcase
  end

  always_comb begin
    if (cmd_i.clr_step) begin
      waddr = clr_q;
      wdata = '0;
    end else begin
      waddr = slot_q;
      wdata = {key_q, hit ? count_inc : 32'd1};
    end
  end

  hkct_ram #(
    .ADDR_W (SLOT_BITS),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en || cmd_i.clr_step),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    drop_d = drop_q;
    if (cmd_i.clr_step) begin
      drop_d = '0;
    end else if (cmd_i.drop_inc) begin
      drop_d = drop_inc;
    end
  end

  always_comb begin
    res_key_d   = '0;
    res_count_d = '0;
    res_drops_d = drop_q;
    case (cmd_i.res_kind)
      hkct_pkg::ST_HIT: begin
        res_key_d   = key_q;
        res_count_d = count_inc;
      end
      hkct_pkg::ST_INSERT: begin
        res_key_d   = key_q;
        res_count_d = 32'd1;
      end
      hkct_pkg::ST_FULL: begin
        res_drops_d = drop_inc;
      end
      hkct_pkg::ST_READ: begin
        res_key_d   = rd_key;
        res_count_d = rd_count;
      end
      hkct_pkg::ST_CLEARED: begin
        res_drops_d = '0;
      end
      default: begin
        res_drops_d = drop_q;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q && !rsp_ready_i;
    if (cmd_i.res_load) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      drop_q      <= '0;
      clr_q       <= '0;
    end else begin
      res_valid_q <= res_valid_d;
      drop_q      <= drop_d;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q  <= key_i;
      prod_q <= key_i * hkct_pkg::HASH_MULT;
      idx_q  <= SLOT_BITS'(slot_index_i);
    end
    if (cmd_i.rd_en) begin
      slot_q  <= slot_d;
      probe_q <= probe_d;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_kind;
      res_key_q    <= res_key_d;
      res_count_q  <= res_count_d;
      res_drops_q  <= res_drops_d;
    end
  end

  assign status_o.req_op       = opcode_i;
  assign status_o.req_key_zero = (key_i == '0);
  assign status_o.hit          = hit;
  assign status_o.empty        = (rd_key == '0);
  assign status_o.probe_last   = (probe_q == PW'(PROBE_LIMIT - 1));
  assign status_o.clr_last     = (clr_q == {SLOT_BITS{1'b1}});
  assign status_o.out_free     = out_free;

  assign rsp_valid_o  = res_valid_q;
  assign rsp_status_o = res_status_q;
  assign rsp_key_o    = res_key_q;
  assign rsp_count_o  = res_count_q;
  assign rsp_drops_o  = res_drops_q;

endmodule

### design/hkct_ctrl.sv
// Controller state machine of the table unit: sequences clear sweeps, probes
// and reads, and commands the datapath. Depends on hkct_pkg.
module hkct_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hkct_pkg::dp_status_t status_i,
  output hkct_pkg::dp_cmd_t    cmd_o
);

  hkct_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_ready_o = (state_q == hkct_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hkct_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.rd_sel   = hkct_pkg::RD_HOME;
    cmd_o.res_kind = hkct_pkg::ST_HIT;
    cmd_o.capture  = accept;
    case (state_q)
      hkct_pkg::S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = hkct_pkg::S_IDLE;
        end
      end
      hkct_pkg::S_IDLE: begin
        if (accept) begin
          case (status_i.req_op)
            hkct_pkg::OP_COUNT: begin
              state_d = status_i.req_key_zero ? hkct_pkg::S_RESP_ZERO : hkct_pkg::S_HOME;
            end
            hkct_pkg::OP_READ:  state_d = hkct_pkg::S_READ;
            hkct_pkg::OP_CLEAR: state_d = hkct_pkg::S_CLEAR;
            default:            state_d = hkct_pkg::S_IDLE;
          endcase
        end
      end
      hkct_pkg::S_HOME: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = hkct_pkg::RD_HOME;
        state_d      = hkct_pkg::S_PROBE;
      end
      hkct_pkg::S_PROBE: begin
        if (status_i.hit || status_i.empty) begin
          cmd_o.res_kind = status_i.hit ? hkct_pkg::ST_HIT : hkct_pkg::ST_INSERT;
          if (status_i.out_free) begin
            cmd_o.wr_en    = 1'b1;
            cmd_o.res_load = 1'b1;
            state_d        = hkct_pkg::S_IDLE;
          end
        end else if (status_i.probe_last) begin
          cmd_o.res_kind = hkct_pkg::ST_FULL;
          if (status_i.out_free) begin
            cmd_o.drop_inc = 1'b1;
            cmd_o.res_load = 1'b1;
            state_d        = hkct_pkg::S_IDLE;
          end
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = hkct_pkg::RD_NEXT;
        end
      end
      hkct_pkg::S_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = hkct_pkg::RD_INDEX;
        state_d      = hkct_pkg::S_DATA;
      end
      hkct_pkg::S_DATA: begin
        cmd_o.res_kind = hkct_pkg::ST_READ;
        if (status_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = hkct_pkg::S_IDLE;
        end
      end
      hkct_pkg::S_CLEAR: begin
        if (status_i.out_free || !status_i.clr_last) begin
          cmd_o.clr_step = 1'b1;
        end
        if (status_i.clr_last && status_i.out_free) begin
          cmd_o.res_kind = hkct_pkg::ST_CLEARED;
          cmd_o.res_load = 1'b1;
          state_d        = hkct_pkg::S_IDLE;
        end
      end
      hkct_pkg::S_RESP_ZERO: begin
        cmd_o.res_kind = hkct_pkg::ST_ZERO_KEY;
        if (status_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = hkct_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hkct_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### design/hashed_key_counter_table_unit.sv
// Top level of the hashed key counter table: a controller and a datapath.
// Depends on hkct_pkg, hkct_if, hkct_ctrl, hkct_datapath, assert_macros.svh.
//
// Histogram table of 2**SLOT_BITS slots keyed by 32-bit words. One request
// word is taken at a time; the next is accepted as soon as the previous
// result sits in the output register, even if that result is not yet taken.
// A count request hashes the key (multiply by 2654435761, keep the top
// SLOT_BITS bits) in the accept cycle, reads the home slot in the next
// cycle, and then checks one slot per cycle on the single read port of the
// slot memory, up to PROBE_LIMIT slots in all with the home slot. A hit
// bumps the count, an empty slot takes the key, and a failed probe run
// bumps the drop counter. A zero key is answered without a memory read; a
// slot read answers once its slot has been read. A clear request sweeps the
// memory one slot per cycle through the write port, the last slot waiting
// for a free output register, and it also zeroes the drop counter. A result
// that cannot be loaded because the previous one is still waiting in the
// output register holds the unit until that word is taken. The same sweep
// runs once after reset: no request is accepted until it has cleared every
// slot. Opcode 3 is accepted and dropped without a result.

`include "assert_macros.svh"

module hashed_key_counter_table_unit #(
  parameter int unsigned SLOT_BITS   = hkct_pkg::SLOT_BITS_DEF,
  parameter int unsigned PROBE_LIMIT = hkct_pkg::PROBE_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hkct_req_if.sink   req_i,
  hkct_rsp_if.source rsp_o
);

  hkct_pkg::dp_cmd_t    cmd;
  hkct_pkg::dp_status_t status;
  logic                 in_ready;

  // Sequence the work of each request word.
  hkct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  // Hold the table, the drop counter and the result register.
  hkct_datapath #(
    .SLOT_BITS   (SLOT_BITS),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .opcode_i     (req_i.opcode),
    .key_i        (req_i.key),
    .slot_index_i (req_i.slot_index),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .rsp_key_o    (rsp_o.slot_key),
    .rsp_count_o  (rsp_o.slot_count),
    .rsp_drops_o  (rsp_o.drops)
  );

  // Never take a request word while the memory is being swept.
  `HKCT_ASSERT_NEVER(a_no_rdy_sweep, clk_i, rst_ni, cmd.clr_step && in_ready, "ready in sweep")
  // Never overwrite a result that is still waiting.
  `HKCT_ASSERT(a_load_free, clk_i, rst_ni, cmd.res_load |-> status.out_free, "load over busy")
  // Never write a slot update and a clear in the same cycle.
  `HKCT_ASSERT_NEVER(a_one_writer, clk_i, rst_ni, cmd.wr_en && cmd.clr_step, "two memory writers")
  // A loaded result shows up on the response channel next cycle.
  `HKCT_ASSERT(a_load_shows, clk_i, rst_ni, cmd.res_load |=> rsp_o.valid, "result not shown")

endmodule

### tb/hashed_key_counter_table_unit_tb.sv
// Self-checking bench for hashed_key_counter_table_unit: a directed table, then random words.
// Depends on hkct_pkg, the hkct_req_if/hkct_rsp_if interfaces and the unit's RTL.
module hashed_key_counter_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hkct_pkg::*;

  localparam int unsigned SLOTS        = 1 << SLOT_BITS_DEF;
  localparam int unsigned SLOT_MASK    = SLOTS - 1;
  localparam int unsigned HASH_SHIFT   = WORD_W - SLOT_BITS_DEF;
  localparam int unsigned RANDOM_WORDS = 450;
  // A clear sweeps every slot, and so does the pass after reset: leave room for both.
  localparam int unsigned IDLE_LIMIT   = 4 * (SLOTS + 64);
  localparam int unsigned DRAIN_CYCLES = 2 * PROBE_LIMIT_DEF + 16;
  localparam int unsigned POOL_CAP     = 48;

  // The one opcode the unit takes and throws away.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CHOKED,
    RX_BEAT
  } rx_mode_e;

  typedef struct packed {
    status_e           status;
    logic [WORD_W-1:0] slot_key;
    logic [WORD_W-1:0] slot_count;
    logic [WORD_W-1:0] drops;
  } table_result_t;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [WORD_W-1:0]   key;
    logic [INDEX_W-1:0]  idx;
    bit                  fixed;
    table_result_t       want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  hkct_req_if req_if ();
  hkct_rsp_if rsp_if ();

  hashed_key_counter_table_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Shadow copy of the table, updated as each request word is accepted.
  logic [WORD_W-1:0] shadow_keys   [SLOTS];
  logic [WORD_W-1:0] shadow_counts [SLOTS];
  logic [WORD_W-1:0] shadow_drops;

  table_result_t     pending_results [$];
  logic [WORD_W-1:0] key_pool [$];
  logic [WORD_W-1:0] hash_inverse;

  int mismatches  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int words_sent  = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void shadow_wipe();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_keys[i]   = '0;
      shadow_counts[i] = '0;
    end
    shadow_drops = '0;
  endfunction

  function automatic int unsigned home_slot(input logic [WORD_W-1:0] key);
    logic [WORD_W-1:0] prod;
    prod = key * HASH_MULT;
    return int'(prod >> HASH_SHIFT);
  endfunction

  // Build a key whose hash lands on the given home slot: pick the product,
  // then undo the multiply with the inverse of the odd multiplier.
  function automatic logic [WORD_W-1:0] key_for_home(input int unsigned home);
    logic [WORD_W-1:0] target;
    target = home;
    target = (target << HASH_SHIFT) | ($urandom >> SLOT_BITS_DEF);
    if (target == '0) target = 32'd1;
    return target * hash_inverse;
  endfunction

  // Apply one request word to the shadow table; return 0 when it yields no result.
  function automatic bit predict_table_word(input logic [OPCODE_W-1:0] op,
                                            input logic [WORD_W-1:0] key,
                                            input logic [INDEX_W-1:0] idx,
                                            output table_result_t res);
    int unsigned home;
    int unsigned s;
    res = '0;
    case (op)
      OP_COUNT: begin
        if (key == '0) begin
          res = '{ST_ZERO_KEY, '0, '0, shadow_drops};
          return 1'b1;
        end
        home = home_slot(key);
        for (int p = 0; p < PROBE_LIMIT_DEF; p++) begin
          s = (home + p) & SLOT_MASK;
          if (shadow_keys[s] == key) begin
            shadow_counts[s] = shadow_counts[s] + 32'd1;
            res = '{ST_HIT, key, shadow_counts[s], shadow_drops};
            return 1'b1;
          end
          if (shadow_keys[s] == '0) begin
            shadow_keys[s]   = key;
            shadow_counts[s] = 32'd1;
            res = '{ST_INSERT, key, 32'd1, shadow_drops};
            return 1'b1;
          end
        end
        shadow_drops = shadow_drops + 32'd1;
        res = '{ST_FULL, '0, '0, shadow_drops};
        return 1'b1;
      end
      OP_READ: begin
        s = idx & SLOT_MASK;
        res = '{ST_READ, shadow_keys[s], shadow_counts[s], shadow_drops};
        return 1'b1;
      end
      OP_CLEAR: begin
        shadow_wipe();
        res = '{ST_CLEARED, '0, '0, '0};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stim_row_t open_row(input logic [OPCODE_W-1:0] op,
                                         input logic [WORD_W-1:0] key,
                                         input logic [INDEX_W-1:0] idx);
    stim_row_t row;
    row.op    = op;
    row.key   = key;
    row.idx   = idx;
    row.fixed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic stim_row_t fixed_row(input logic [OPCODE_W-1:0] op,
                                          input logic [WORD_W-1:0] key,
                                          input logic [INDEX_W-1:0] idx,
                                          input status_e st,
                                          input logic [WORD_W-1:0] k,
                                          input logic [WORD_W-1:0] c,
                                          input logic [WORD_W-1:0] d);
    stim_row_t row;
    row       = open_row(op, key, idx);
    row.fixed = 1'b1;
    row.want  = '{st, k, c, d};
    return row;
  endfunction

  function automatic void remember_key(input logic [WORD_W-1:0] key);
    if (key == '0) return;
    key_pool.push_back(key);
    if (key_pool.size() > POOL_CAP) key_pool.delete($urandom_range(0, POOL_CAP));
  endfunction

  task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want) flag_mismatch(what, got, want);
  endtask

  // Present one request word, hold it until accepted, record what it should
  // produce, then pace the sender: stay in the burst or open a gap.
  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] key,
                           input logic [INDEX_W-1:0] idx, input bit fixed,
                           input table_result_t want);
    table_result_t predicted;
    int gap;
    @(negedge clk_i);
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.key        <= key;
    req_if.slot_index <= idx;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (predict_table_word(op, key, idx, predicted)) begin
      pending_results.push_back(fixed ? want : predicted);
      words_sent++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Receiver: pick a stall mode for a random stretch, drive ready from it.
  initial begin
    rx_mode_e    mode;
    int unsigned left;
    mode         = RX_OPEN;
    left         = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        RX_OPEN:   rsp_if.ready <= 1'b1;
        RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
        RX_CHOKED: rsp_if.ready <= ($urandom_range(0, 7) == 0);
        default:   rsp_if.ready <= (left % 4 != 0);
      endcase
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    table_result_t oldest;
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result word with nothing pending", WORD_W'(rsp_if.status), '0);
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", WORD_W'(rsp_if.status), WORD_W'(oldest.status));
        check_field("slot_key", rsp_if.slot_key, oldest.slot_key);
        check_field("slot_count", rsp_if.slot_count, oldest.slot_count);
        check_field("drops", rsp_if.drops, oldest.drops);
      end
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("hashed_key_counter_table_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t         plan [$];
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] wrap_key;
    logic [INDEX_W-1:0] idx;
    int unsigned       h;
    int                r;
    int                n;

    req_if.valid      = 1'b0;
    req_if.opcode     = OP_COUNT;
    req_if.key        = '0;
    req_if.slot_index = '0;
    rst_ni            = 1'b0;
    shadow_wipe();

    // Newton steps for the inverse of the odd multiplier modulo 2**32.
    hash_inverse = HASH_MULT;
    repeat (5) hash_inverse = hash_inverse * (32'd2 - HASH_MULT * hash_inverse);

    // Directed table. Rows with a typed-in result are the obvious ones:
    // an empty table, a rejected zero key, first insert and first hit, a clear.
    plan.push_back(fixed_row(OP_READ, '0, '0, ST_READ, '0, '0, '0));
    plan.push_back(fixed_row(OP_READ, '1, '1, ST_READ, '0, '0, '0));
    plan.push_back(fixed_row(OP_COUNT, '0, '1, ST_ZERO_KEY, '0, '0, '0));
    plan.push_back(fixed_row(OP_COUNT, '1, '0, ST_INSERT, '1, 32'd1, '0));
    plan.push_back(fixed_row(OP_COUNT, '1, '1, ST_HIT, '1, 32'd2, '0));
    plan.push_back(fixed_row(OP_COUNT, 32'd1, '0, ST_INSERT, 32'd1, 32'd1, '0));
    plan.push_back(open_row(OP_READ, 32'h5555_5555, INDEX_W'(home_slot('1))));
    plan.push_back(open_row(OP_UNUSED, '1, '1));
    // Pile keys on the last two homes so the probe runs wrap to slots 0 and 1.
    wrap_key = key_for_home(SLOTS - 2);
    plan.push_back(open_row(OP_COUNT, wrap_key, '0));
    plan.push_back(open_row(OP_COUNT, key_for_home(SLOTS - 2), '1));
    plan.push_back(open_row(OP_COUNT, key_for_home(SLOTS - 2), '1));
    plan.push_back(open_row(OP_COUNT, key_for_home(SLOTS - 1), '0));
    plan.push_back(open_row(OP_COUNT, wrap_key, '0));
    plan.push_back(open_row(OP_READ, '0, '0));
    plan.push_back(open_row(OP_READ, '1, INDEX_W'(1)));
    plan.push_back(open_row(OP_READ, '0, INDEX_W'(SLOTS - 2)));
    plan.push_back(open_row(OP_COUNT, 32'h8000_0000, '0));
    plan.push_back(open_row(OP_COUNT, 32'h5555_5555, '1));
    plan.push_back(open_row(OP_COUNT, 32'hAAAA_AAAA, 13'h0AAA));
    plan.push_back(open_row(OP_UNUSED, '0, '0));
    plan.push_back(fixed_row(OP_CLEAR, 32'hAAAA_AAAA, '1, ST_CLEARED, '0, '0, '0));
    plan.push_back(fixed_row(OP_READ, '0, INDEX_W'(SLOTS - 2), ST_READ, '0, '0, '0));
    plan.push_back(fixed_row(OP_COUNT, '1, '0, ST_INSERT, '1, 32'd1, '0));

    // Hold reset, then release it at a falling edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) send_word(plan[i].op, plan[i].key, plan[i].idx, plan[i].fixed,
                                plan[i].want);

    // Random words: mostly counts on pool keys or fresh ones, with reads aimed at
    // their slots, now and then a run of colliding keys that overflows the
    // probe window, plus zero keys, ignored opcodes and rare clears.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        h = ($urandom_range(0, 2) == 0) ? SLOTS - $urandom_range(1, 8)
                                         : $urandom_range(0, SLOTS - 1);
        n = PROBE_LIMIT_DEF + $urandom_range(1, 4);
        repeat (n) begin
          k = key_for_home(h);
          send_word(OP_COUNT, k, INDEX_W'($urandom), 1'b0, '0);
          remember_key(k);
        end
      end else if (r < 40) begin
        k = (key_pool.size() == 0) ? $urandom : key_pool[$urandom_range(0, key_pool.size() - 1)];
        send_word(OP_COUNT, k, INDEX_W'($urandom), 1'b0, '0);
      end else if (r < 60) begin
        if (key_pool.size() != 0 && $urandom_range(0, 1) == 1) begin
          k   = key_pool[$urandom_range(0, key_pool.size() - 1)];
          idx = INDEX_W'((home_slot(k) + $urandom_range(0, PROBE_LIMIT_DEF + 1)) & SLOT_MASK);
        end else begin
          idx = INDEX_W'($urandom);
        end
        send_word(OP_READ, $urandom, idx, 1'b0, '0);
      end else if (r < 64) begin
        send_word(OP_COUNT, '0, INDEX_W'($urandom), 1'b0, '0);
      end else if (r < 69) begin
        send_word(OP_UNUSED, $urandom, INDEX_W'($urandom), 1'b0, '0);
      end else if (r < 70) begin
        send_word(OP_CLEAR, $urandom, INDEX_W'($urandom), 1'b0, '0);
      end else begin
        k = $urandom;
        send_word(OP_COUNT, k, INDEX_W'($urandom), 1'b0, '0);
        remember_key(k);
      end
    end

    // Drop valid, drain the results still owed, then let the pipe settle.
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("hashed_key_counter_table_unit verification clean");
    end else begin
      $display("hashed_key_counter_table_unit verification failed");
    end
    $finish;
  end

endmodule
